### design/fist_pkg.sv
// fist_pkg: shared constants, types and helpers for the flow interval table.
// Used by fist_store and flow_interval_stats_table; no dependencies.
`timescale 1ns / 1ps
package fist_pkg;

  // Table geometry: NSETS sets of WAYS ways; NSETS is a power of two
  localparam int ENTRIES = 4096;
  localparam int WAYS    = 4;
  localparam int NSETS   = ((ENTRIES / WAYS) > 0) ? (ENTRIES / WAYS) : 1;
  localparam int SLOTS   = NSETS * WAYS;
  localparam int SET_W   = (NSETS > 1) ? $clog2(NSETS) : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOT_W  = $clog2(SLOTS);

  // Configuration
  localparam int CFG_W = 40;
  localparam logic CFG_MIN_INTERVAL = 1'b0;
  localparam logic CFG_MAX_INTERVAL = 1'b1;
  localparam logic [CFG_W-1:0] MIN_INTERVAL_RST = 40'd100000000;
  localparam logic [CFG_W-1:0] MAX_INTERVAL_RST = 40'd600000000000;

  // One flow entry
  typedef struct packed {
    logic [31:0] proc_tag;
    logic [47:0] dest_tag;
    logic [63:0] last_time;
    logic [63:0] sum;
    logic [31:0] cnt;
    logic [39:0] mn;
    logic [39:0] mx;
    logic [31:0] snd;
  } entry_t;

  // Per-set valid bits and LRU ranks (0 = most recent)
  typedef struct packed {
    logic [WAYS-1:0]                 vld;
    logic [WAYS-1:0][WAY_W-1:0]      rank;
  } meta_t;

  // Set state after reset: nothing valid, ranks equal way number
  function automatic meta_t meta_init();
    meta_t m;
    m.vld = '0;
    for (int w = 0; w < WAYS; w++) m.rank[w] = WAY_W'(w);
    return m;
  endfunction

  // Make a way most recently used and mark it valid
  function automatic meta_t meta_touch(meta_t m, logic [WAY_W-1:0] way);
    meta_t r;
    logic [WAY_W-1:0] old;
    r   = m;
    old = m.rank[way];
    for (int w = 0; w < WAYS; w++) begin
      if (m.rank[w] < old) r.rank[w] = m.rank[w] + 1'b1;
    end
    r.rank[way] = '0;
    r.vld[way]  = 1'b1;
    return r;
  endfunction

  // Least recently used way: the one holding the top rank
  function automatic logic [WAY_W-1:0] meta_victim(meta_t m);
    logic [WAY_W-1:0] v;
    v = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (m.rank[w] == WAY_W'(WAYS - 1)) v = WAY_W'(w);
    end
    return v;
  endfunction

endpackage

### design/fist_store.sv
// fist_store: set metadata memory and flow entry memory, registered reads.
// Depends on fist_pkg.
`timescale 1ns / 1ps
module fist_store (
  input  logic                          clk,
  input  logic [fist_pkg::SET_W-1:0]    meta_raddr,
  output fist_pkg::meta_t               meta_rdata,
  input  logic                          meta_we,
  input  logic [fist_pkg::SET_W-1:0]    meta_waddr,
  input  fist_pkg::meta_t               meta_wdata,
  input  logic [fist_pkg::SLOT_W-1:0]   ent_raddr,
  output fist_pkg::entry_t              ent_rdata,
  input  logic                          ent_we,
  input  logic [fist_pkg::SLOT_W-1:0]   ent_waddr,
  input  fist_pkg::entry_t              ent_wdata
);

  fist_pkg::meta_t  meta_mem [fist_pkg::NSETS];
  fist_pkg::entry_t ent_mem  [fist_pkg::SLOTS];

  // Set metadata
  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    meta_rdata <= meta_mem[meta_raddr];
  end

  // Flow entries
  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    ent_rdata <= ent_mem[ent_raddr];
  end

endmodule

### design/flow_interval_stats_table.sv
// flow_interval_stats_table: per-flow send interval statistics, 4-way LRU table.
// Each way scanned takes a read state and a compare state; a hit then runs up to 6 shared
// 65-bit adder steps. The next word is taken once back in S_IDLE; a zero pid is dropped.
// Reset: synchronous, active low; then a clearing pass over all NSETS (1024) sets
// rewrites every set's valid bits and LRU ranks while in_stall is held high.
// Depends on fist_pkg, fist_store.
`timescale 1ns / 1ps
module flow_interval_stats_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [39:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_proc_id,
  input  logic [31:0] in_dest_addr,
  input  logic [15:0] in_dest_port,
  input  logic [63:0] in_now_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_new_flow,
  output logic        out_evicted,
  output logic        out_interval_taken,
  output logic [31:0] out_sends,
  output logic [31:0] out_intervals,
  output logic [63:0] out_interval_total,
  output logic [39:0] out_shortest,
  output logic [39:0] out_longest
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_CMP, S_MISS, S_IV, S_LO, S_HI,
    S_SUM, S_SHORT, S_LONG, S_WR, S_DONE
  } state_t;

  state_t                         state_r;
  logic [fist_pkg::SET_W-1:0]     clr_r;
  logic [fist_pkg::SET_W-1:0]     set_r;
  logic [fist_pkg::WAY_W-1:0]     way_r;
  logic [31:0]                    pid_r;
  logic [47:0]                    dtag_r;
  logic [63:0]                    now_r;
  logic [63:0]                    iv_r;
  logic                           lo_ok_r;
  logic                           new_r, ev_r, taken_r;
  fist_pkg::entry_t               ent_r;
  logic [39:0]                    min_int_r, max_int_r;

  // Storage interface
  fist_pkg::meta_t                meta_rdata, meta_wdata;
  fist_pkg::entry_t               ent_rdata, ent_wdata;
  logic [fist_pkg::SET_W-1:0]     meta_raddr, meta_waddr;
  logic [fist_pkg::SLOT_W-1:0]    slot;
  logic                           meta_we, ent_we;

  // Set index from the XOR fold of the key
  logic [31:0]                    fold;
  logic [15:0]                    fold16;
  logic [fist_pkg::SET_W-1:0]     set_in;
  logic                           accept;

  assign fold   = in_proc_id ^ in_dest_addr ^ {16'h0, in_dest_port};
  assign fold16 = fold[15:0] ^ fold[31:16];
  assign set_in = fold16[fist_pkg::SET_W-1:0]
                & fist_pkg::SET_W'(fist_pkg::NSETS - 1);
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign meta_raddr = (state_r == S_IDLE) ? set_in : set_r;
  assign slot = fist_pkg::SLOT_W'(set_r) * fist_pkg::SLOT_W'(fist_pkg::WAYS)
              + fist_pkg::SLOT_W'(way_r);

  // Write back: clearing pass or the touched set
  always_comb begin
    meta_we    = (state_r == S_CLR) || (state_r == S_WR);
    meta_waddr = (state_r == S_CLR) ? clr_r : set_r;
    meta_wdata = (state_r == S_CLR) ? fist_pkg::meta_init()
                                    : fist_pkg::meta_touch(meta_rdata, way_r);
    ent_we     = (state_r == S_WR);
    ent_wdata  = ent_r;
    ent_wdata.last_time = now_r;
  end

  fist_store u_store (
    .clk        (clk),
    .meta_raddr (meta_raddr),
    .meta_rdata (meta_rdata),
    .meta_we    (meta_we),
    .meta_waddr (meta_waddr),
    .meta_wdata (meta_wdata),
    .ent_raddr  (slot),
    .ent_rdata  (ent_rdata),
    .ent_we     (ent_we),
    .ent_waddr  (slot),
    .ent_wdata  (ent_wdata)
  );

  // Shared adder: a + b, or a - b with carry meaning a >= b
  logic [63:0] alu_a, alu_b;
  logic        alu_sub;
  logic [64:0] alu_res;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    unique case (state_r)
      S_IV:    begin alu_a = now_r;                alu_b = ent_r.last_time;    end
      S_LO:    begin alu_a = iv_r;                 alu_b = {24'h0, min_int_r}; end
      S_HI:    begin alu_a = {24'h0, max_int_r};   alu_b = iv_r;               end
      S_SUM:   begin alu_a = ent_r.sum;            alu_b = iv_r; alu_sub = 1'b0; end
      S_SHORT: begin alu_a = iv_r;                 alu_b = {24'h0, ent_r.mn};  end
      S_LONG:  begin alu_a = {24'h0, ent_r.mx};    alu_b = iv_r;               end
      default: ;
    endcase
    alu_res = {1'b0, alu_a} + {1'b0, alu_b ^ {64{alu_sub}}} + {64'h0, alu_sub};
  end

  // Tag compare for the way under test
  logic hit;
  assign hit = meta_rdata.vld[way_r] && (ent_rdata.proc_tag == pid_r)
            && (ent_rdata.dest_tag == dtag_r);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_int_r <= fist_pkg::MIN_INTERVAL_RST;
      max_int_r <= fist_pkg::MAX_INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        fist_pkg::CFG_MIN_INTERVAL: min_int_r <= cfg_data;
        fist_pkg::CFG_MAX_INTERVAL: max_int_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      // drain the result word; S_DONE reloads it below
      if (out_valid && !out_stall && (state_r != S_DONE)) out_valid <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == fist_pkg::SET_W'(fist_pkg::NSETS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept && (in_proc_id != '0)) begin
            set_r   <= set_in;
            way_r   <= '0;
            pid_r   <= in_proc_id;
            dtag_r  <= {in_dest_addr, in_dest_port};
            now_r   <= in_now_time;
            new_r   <= 1'b0;
            ev_r    <= 1'b0;
            taken_r <= 1'b0;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_CMP;
        S_CMP: begin
          ent_r <= ent_rdata;
          if (hit) begin
            state_r <= S_IV;
          end else if (way_r == fist_pkg::WAY_W'(fist_pkg::WAYS - 1)) begin
            state_r <= S_MISS;
          end else begin
            way_r   <= way_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_MISS: begin
          way_r          <= fist_pkg::meta_victim(meta_rdata);
          ev_r           <= meta_rdata.vld[fist_pkg::meta_victim(meta_rdata)];
          new_r          <= 1'b1;
          ent_r.proc_tag <= pid_r;
          ent_r.dest_tag <= dtag_r;
          ent_r.sum      <= '0;
          ent_r.cnt      <= '0;
          ent_r.mn       <= '0;
          ent_r.mx       <= '0;
          ent_r.snd      <= 32'd1;
          state_r        <= S_WR;
        end
        S_IV: begin
          if (ent_r.snd != '1) ent_r.snd <= ent_r.snd + 1'b1;
          iv_r    <= alu_res[63:0];
          state_r <= (ent_r.last_time == '0) ? S_WR : S_LO;
        end
        S_LO: begin
          lo_ok_r <= alu_res[64];
          state_r <= S_HI;
        end
        S_HI: state_r <= (lo_ok_r && alu_res[64]) ? S_SUM : S_WR;
        S_SUM: begin
          taken_r   <= 1'b1;
          ent_r.sum <= alu_res[63:0];
          if (ent_r.cnt != '1) ent_r.cnt <= ent_r.cnt + 1'b1;
          state_r   <= S_SHORT;
        end
        S_SHORT: begin
          // accepted interval is at most max_interval, so it fits 40 bits
          if (!alu_res[64] || (ent_r.mn == '0)) ent_r.mn <= iv_r[39:0];
          state_r <= S_LONG;
        end
        S_LONG: begin
          if (!alu_res[64]) ent_r.mx <= iv_r[39:0];
          state_r <= S_WR;
        end
        S_WR: state_r <= S_DONE;
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid          <= 1'b1;
            out_new_flow       <= new_r;
            out_evicted        <= ev_r;
            out_interval_taken <= taken_r;
            out_sends          <= ent_r.snd;
            out_intervals      <= ent_r.cnt;
            out_interval_total <= ent_r.sum;
            out_shortest       <= ent_r.mn;
            out_longest        <= ent_r.mx;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### design/fist_checker.sv
// fist_checker: port-level assertions for flow_interval_stats_table, with bind.
// Depends on flow_interval_stats_table ports only.
`timescale 1ns / 1ps
module fist_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_new_flow,
  input logic        out_evicted,
  input logic        out_interval_taken,
  input logic [31:0] out_sends,
  input logic [31:0] out_intervals,
  input logic [63:0] out_interval_total
);

  // Reset starts the clearing pass, so no word is taken right after it
  a_clear_after_rst: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken right after reset");

  // A stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sends)
                               && $stable(out_interval_total))
    else $error("stalled result changed");

  // Only a new flow can evict
  a_evict_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_new_flow |-> !out_evicted)
    else $error("eviction without new flow");

  // A new flow starts with one send and empty statistics
  a_new_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_flow |-> out_sends == 32'd1 && !out_interval_taken
                                  && out_intervals == '0 && out_interval_total == '0)
    else $error("new flow with stale statistics");

endmodule

bind flow_interval_stats_table fist_checker u_fist_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_new_flow       (out_new_flow),
  .out_evicted        (out_evicted),
  .out_interval_taken (out_interval_taken),
  .out_sends          (out_sends),
  .out_intervals      (out_intervals),
  .out_interval_total (out_interval_total)
);
